// ===== rtl/b64e_pkg.sv =====
package b64e_pkg;

    // Position of the next byte within its three-byte group.
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Up to four characters produced by one input byte.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            last;
    } job_t;

    // Map a six-bit symbol to its character in the standard alphabet.
    function automatic logic [7:0] sym_to_ascii(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] res;
        w = {2'b00, v};
        if (v < 6'd26) begin
            res = 8'(8'd65 + w);
        end
        else if (v < 6'd52) begin
            res = 8'(8'd97 + w - 8'd26);
        end
        else if (v < 6'd62) begin
            res = 8'(8'd48 + w - 8'd52);
        end
        else if (v == 6'd62) begin
            res = 8'h2B;
        end
        else begin
            res = 8'h2F;
        end
        return res;
    endfunction

endpackage

// ===== rtl/b64e_front.sv =====
module b64e_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             queue_full,
    output logic             in_ready,
    output logic             push,
    output b64e_pkg::job_t   job
);
    import b64e_pkg::*;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] carry_reg;
    logic [3:0] carry_next;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        job.chars    = '{default: PAD_CHAR};
        job.last     = in_last;
        job.last_idx = 2'd0;
        phase_next   = phase_reg;
        carry_next   = carry_reg;
        unique case (phase_reg)
            PHASE_SECOND:
            begin
                job.chars[0] = sym_to_ascii({carry_reg[1:0], in_byte[7:4]});
                job.chars[1] = sym_to_ascii({in_byte[3:0], 2'b00});
                job.last_idx = in_last ? 2'd2 : 2'd0;
                carry_next   = in_byte[3:0];
                phase_next   = PHASE_THIRD;
            end
            PHASE_THIRD:
            begin
                job.chars[0] = sym_to_ascii({carry_reg, in_byte[7:6]});
                job.chars[1] = sym_to_ascii(in_byte[5:0]);
                job.last_idx = 2'd1;
                carry_next   = 4'd0;
                phase_next   = PHASE_FIRST;
            end
            default:
            begin
                // The unused fourth phase code behaves as the first.
                job.chars[0] = sym_to_ascii(in_byte[7:2]);
                job.chars[1] = sym_to_ascii({in_byte[1:0], 4'b0000});
                job.last_idx = in_last ? 2'd3 : 2'd0;
                carry_next   = {2'b00, in_byte[1:0]};
                phase_next   = PHASE_SECOND;
            end
        endcase
        if (in_last)
        begin
            phase_next = PHASE_FIRST;
            carry_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_FIRST;
            carry_reg <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ===== rtl/b64e_queue.sv =====
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64e_pkg::job_t   push_job,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output b64e_pkg::job_t   head_job
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign head_job = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

// ===== rtl/b64e_back.sv =====
module b64e_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  b64e_pkg::job_t   q_job,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_char,
    output logic             out_last
);
    import b64e_pkg::*;

    job_t       job_reg;
    logic       valid_reg;
    logic       valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       at_end;
    logic       out_fire;

    assign at_end   = (idx_reg == job_reg.last_idx);
    assign out_fire = valid_reg && out_ready;
    assign pop      = q_valid && (!valid_reg || (out_fire && at_end));

    assign out_valid = valid_reg;
    assign out_char  = job_reg.chars[idx_reg];
    assign out_last  = job_reg.last && at_end;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (out_fire && at_end)
        begin
            valid_next = 1'b0;
        end
        else if (out_fire)
        begin
            idx_next = 2'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // The character index never runs past the last character of the group.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg <= job_reg.last_idx))
        else $error("character index beyond last character of group");

    // A character taken before the end of its group leaves the serializer busy.
    a_stay_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !at_end) |=> valid_reg)
        else $error("serializer dropped a group before its end");

    // A character taken mid-group advances the index by exactly one.
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !at_end) |=> (idx_reg == 2'($past(idx_reg) + 1'b1)))
        else $error("character index did not advance by one");

    // A new group is never loaded while characters of the current one remain.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !(out_fire && at_end)) |-> !pop)
        else $error("group loaded over an unfinished one");

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// Base64 stream encoder (standard alphabet A-Z, a-z, 0-9, '+', '/', with '='
// padding). Each input request carries one byte; tlast marks the final byte of
// a message. The encoder emits one ASCII character per output request, and
// tlast on the output marks the final character of the encoded message. The
// first and second bytes of a three-byte group each produce one character, the
// third produces two; the final byte flushes the partial group with zero bits
// and pads it with '=' to four characters. An empty message produces nothing.
// Throughput: the output side delivers one character per clock while
// m_axis_tready is high, and a byte yields one to four characters (1, 1, 2
// within a group, and 4, 3 or 2 for a final byte by its position), about 4/3
// characters per byte sustained. The single-character output serializer sets
// the pace. The input side takes a byte every cycle as long as the group
// queue between the byte classifier and the serializer has room (QUEUE_DEPTH
// groups), so either side can stall without stopping the other. At the
// earliest, the first character of a byte is offered on the output once the
// byte has passed through a queue entry and the serializer's group register.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast    // last_char
);
    import b64e_pkg::*;

    job_t front_job;
    job_t head_job;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_valid;

    // The classifier tracks the group position and leftover bits, and turns
    // each byte into a complete group of ready-made characters.
    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .queue_full (queue_full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .job        (front_job)
    );

    // The queue decouples byte intake from character output.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .full     (queue_full),
        .valid    (queue_valid),
        .head_job (head_job)
    );

    // The serializer holds one group in registers and sends its characters
    // one per cycle unless stalled, loading the next group as the last is taken.
    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (queue_valid),
        .q_job     (head_job),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
